### sv/pcsm_pkg.sv
package pcsm_pkg;

    // Command codes of the request
    typedef enum logic [2:0] {
        CMD_RD8   = 3'd0,
        CMD_RD16  = 3'd1,
        CMD_RD32  = 3'd2,
        CMD_WR8   = 3'd3,
        CMD_WR16  = 3'd4,
        CMD_WR32  = 3'd5,
        CMD_MASK  = 3'd6,
        CMD_IDENT = 3'd7
    } cmd_t;

    // Byte counter of a mask walk: (start + count) >> 3 fits in 10 bits
    localparam int MBYTE_W = 10;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // capture a request
        logic lane_wb;   // finish one access lane
        logic mask_wb;   // write back one mask byte
        logic clr_wr;    // clearing pass write
        logic load_out;  // load the result register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic lane_last;
        logic mask_none;
        logic byte_last;
        logic clr_last;
    } ctl_sts_t;

endpackage

### sv/pcsm_ctrl.sv
module pcsm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    output logic                m_valid,
    input  logic                m_ready,
    output pcsm_pkg::ctl_cmd_t  cmd,
    input  pcsm_pkg::ctl_sts_t  sts
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LRD   = 7'b0000100,
        S_LWB   = 7'b0001000,
        S_MRD   = 7'b0010000,
        S_MWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Decode commands for the datapath
    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.lane_wb  = (state_reg == S_LWB);
        cmd.mask_wb  = (state_reg == S_MWR);
        cmd.clr_wr   = (state_reg == S_CLEAR);
        cmd.load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    end

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_command == pcsm_pkg::CMD_MASK) state_next = S_MRD;
                    else                                 state_next = S_LRD;
                end
            end
            S_LRD: state_next = S_LWB;
            S_LWB: begin
                if (sts.lane_last) state_next = S_DONE;
                else               state_next = S_LRD;
            end
            S_MRD: begin
                if (sts.mask_none) state_next = S_DONE;
                else               state_next = S_MWR;
            end
            S_MWR: begin
                if (sts.byte_last) state_next = S_DONE;
                else               state_next = S_MRD;
            end
            S_DONE: begin
                if (cmd.load_out) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result register is loaded only when it is free or being drained
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending result");

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while busy");

    // A new result appears only out of the finishing state
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result valid without finishing a request");

endmodule

### sv/pcsm_datapath.sv
module pcsm_datapath #(
    parameter int SPACE_BYTES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcsm_pkg::ctl_cmd_t  cmd,
    output pcsm_pkg::ctl_sts_t  sts,
    input  logic [2:0]          s_command,
    input  logic [9:0]          s_address,
    input  logic [31:0]         s_write_data,
    input  logic [11:0]         s_mask_bit_start,
    input  logic [11:0]         s_mask_bit_count,
    input  logic                s_mask_value,
    input  logic [15:0]         s_vendor_code,
    input  logic [15:0]         s_device_code,
    output logic [31:0]         m_read_data
);

    localparam int AW = $clog2(SPACE_BYTES);
    localparam int BW = pcsm_pkg::MBYTE_W;

    // Configuration bytes and write mask
    logic [7:0] cfg_mem [SPACE_BYTES];
    logic [7:0] msk_mem [SPACE_BYTES];
    logic [7:0] cfg_q, msk_q;

    // Captured request
    logic [9:0]    addr_reg;
    logic [31:0]   wdata_reg;
    logic [1:0]    lane_reg;
    logic [1:0]    last_lane_reg;
    logic          is_read_reg;
    logic          is_write_reg;
    logic          force_reg;
    logic          is_mask_reg;
    logic          mset_reg;
    logic [11:0]   mstart_reg;
    logic [12:0]   mend_reg;
    logic [BW-1:0] byte_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   rdata_reg;
    logic [AW-1:0] clr_reg;

    logic [10:0]   lane_addr;
    logic          lane_in;
    logic          byte_in;
    logic [BW:0]   byte_nx;
    logic [AW-1:0] rd_idx;
    logic [7:0]    lane_byte;
    logic          cfg_we, msk_we;
    logic [AW-1:0] cfg_wa, msk_wa;
    logic [7:0]    cfg_wd, msk_wd;
    logic [7:0]    msk_upd;

    assign lane_addr = {1'b0, addr_reg} + {9'b0, lane_reg};
    assign lane_in   = 32'(lane_addr) < 32'(SPACE_BYTES);
    assign byte_in   = 32'(byte_reg) < 32'(SPACE_BYTES);
    assign byte_nx   = {1'b0, byte_reg} + {{BW{1'b0}}, 1'b1};
    assign rd_idx    = is_mask_reg ? AW'(byte_reg) : AW'(lane_addr);
    assign lane_byte = 8'(wdata_reg >> {lane_reg, 3'b000});

    // Set or clear the mask bits of this byte that fall in the run
    always_comb begin
        logic [12:0] bit_ix;
        for (int b = 0; b < 8; b++) begin
            bit_ix     = {byte_reg, 3'(b)};
            msk_upd[b] = (bit_ix >= {1'b0, mstart_reg} && bit_ix < mend_reg)
                         ? mset_reg : msk_q[b];
        end
    end

    // Write port selection
    always_comb begin
        cfg_we = cmd.clr_wr || (cmd.lane_wb && is_write_reg && lane_in);
        cfg_wa = cmd.clr_wr ? clr_reg : rd_idx;
        if (cmd.clr_wr)     cfg_wd = (clr_reg < AW'(2)) ? 8'hff : 8'h00;
        else if (force_reg) cfg_wd = lane_byte;
        else                cfg_wd = (lane_byte & msk_q) | (cfg_q & ~msk_q);

        msk_we = cmd.clr_wr || (cmd.mask_wb && byte_in);
        msk_wa = cmd.clr_wr ? clr_reg : rd_idx;
        msk_wd = cmd.clr_wr ? 8'h00 : msk_upd;
    end

    always_ff @(posedge aclk) begin
        if (cfg_we) cfg_mem[cfg_wa] <= cfg_wd;
        cfg_q <= cfg_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (msk_we) msk_mem[msk_wa] <= msk_wd;
        msk_q <= msk_mem[rd_idx];
    end

    // Status toward the controller
    always_comb begin
        sts           = '0;
        sts.lane_last = (lane_reg == last_lane_reg);
        sts.mask_none = (mend_reg == {1'b0, mstart_reg}) || !byte_in;
        sts.byte_last = (32'(byte_nx) >= 32'(SPACE_BYTES))
                        || ({byte_nx, 3'b000} >= {1'b0, mend_reg});
        sts.clr_last  = (32'(clr_reg) == 32'(SPACE_BYTES - 1));
    end

    // Advance the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn)        clr_reg <= '0;
        else if (cmd.clr_wr) clr_reg <= clr_reg + AW'(1);
    end

    // Capture the request, step lanes and bytes, gather read data
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg     <= s_address;
            wdata_reg    <= s_write_data;
            lane_reg     <= 2'd0;
            acc_reg      <= '0;
            mset_reg     <= s_mask_value;
            mstart_reg   <= s_mask_bit_start;
            mend_reg     <= {1'b0, s_mask_bit_start} + {1'b0, s_mask_bit_count};
            byte_reg     <= BW'(s_mask_bit_start[11:3]);
            is_read_reg  <= 1'b0;
            is_write_reg <= 1'b0;
            force_reg    <= 1'b0;
            is_mask_reg  <= 1'b0;
            unique case (pcsm_pkg::cmd_t'(s_command))
                pcsm_pkg::CMD_RD8: begin
                    is_read_reg   <= 1'b1;
                    last_lane_reg <= 2'd0;
                end
                pcsm_pkg::CMD_RD16: begin
                    is_read_reg   <= 1'b1;
                    last_lane_reg <= 2'd1;
                end
                pcsm_pkg::CMD_RD32: begin
                    is_read_reg   <= 1'b1;
                    last_lane_reg <= 2'd3;
                end
                pcsm_pkg::CMD_WR8: begin
                    is_write_reg  <= 1'b1;
                    last_lane_reg <= 2'd0;
                end
                pcsm_pkg::CMD_WR16: begin
                    is_write_reg  <= 1'b1;
                    last_lane_reg <= 2'd1;
                end
                pcsm_pkg::CMD_WR32: begin
                    is_write_reg  <= 1'b1;
                    last_lane_reg <= 2'd3;
                end
                pcsm_pkg::CMD_MASK: begin
                    is_mask_reg   <= 1'b1;
                    last_lane_reg <= 2'd0;
                end
                pcsm_pkg::CMD_IDENT: begin
                    // store four bytes at 0..3, mask bypassed
                    is_write_reg  <= 1'b1;
                    force_reg     <= 1'b1;
                    addr_reg      <= '0;
                    wdata_reg     <= {s_device_code, s_vendor_code};
                    last_lane_reg <= 2'd3;
                end
            endcase
        end else begin
            if (cmd.lane_wb) begin
                if (is_read_reg && lane_in) begin
                    acc_reg <= acc_reg | (32'(cfg_q) << {lane_reg, 3'b000});
                end
                lane_reg <= lane_reg + 2'd1;
            end
            if (cmd.mask_wb) byte_reg <= byte_nx[BW-1:0];
        end
        if (cmd.load_out) rdata_reg <= acc_reg;
    end

    assign m_read_data = rdata_reg;

endmodule

### sv/pci_config_space_masked.sv
// Byte-wide store: a read or write steps each lane through S_LRD and S_LWB; identity
// writes four lanes; a mask update steps each byte touched through S_MRD and S_MWR.
// S_DONE then loads the result register, which raises result valid.
// One request at a time; the result register lets the next request in while it waits.
// After reset a clearing pass over all SPACE_BYTES entries loads the store (bytes 0 and 1
// to 0xFF, the rest and the mask to zero); no request is taken until it ends.
module pci_config_space_masked #(
    parameter int SPACE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [9:0]  s_address,
    input  logic [31:0] s_write_data,
    input  logic [11:0] s_mask_bit_start,
    input  logic [11:0] s_mask_bit_count,
    input  logic        s_mask_value,
    input  logic [15:0] s_vendor_code,
    input  logic [15:0] s_device_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data
);

    pcsm_pkg::ctl_cmd_t cmd;
    pcsm_pkg::ctl_sts_t sts;

    // Sequencer
    pcsm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Store, mask and result datapath
    pcsm_datapath #(
        .SPACE_BYTES (SPACE_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_command        (s_command),
        .s_address        (s_address),
        .s_write_data     (s_write_data),
        .s_mask_bit_start (s_mask_bit_start),
        .s_mask_bit_count (s_mask_bit_count),
        .s_mask_value     (s_mask_value),
        .s_vendor_code    (s_vendor_code),
        .s_device_code    (s_device_code),
        .m_read_data      (m_read_data)
    );

endmodule
